// ----- sv/sfl_pkg.sv -----
// Shared constants, coefficient table and control structs for the sawtooth FIR low-pass.
package sfl_pkg;

    // Default sizes
    localparam int TAPS_DEF        = 115;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 24;

    // Phase format and oscillator step after reset
    localparam int          PHASE_BITS = 24;
    localparam logic [23:0] STEP_RESET = 24'd83886;

    // Symmetric low-pass coefficient table, first half plus center, Q1.23
    localparam int ROM_LEN  = 115;
    localparam int ROM_HALF = 57;
    localparam logic signed [23:0] ROM_HALF_TBL [0:ROM_HALF] = '{
        24'sd0,       -24'sd8,       24'sd0,        24'sd72,
        24'sd213,     24'sd343,      24'sd315,      24'sd0,
        -24'sd598,    -24'sd1271,    -24'sd1630,    -24'sd1268,
        24'sd0,       24'sd1924,     24'sd3769,     24'sd4520,
        24'sd3323,    24'sd0,        -24'sd4603,    -24'sd8688,
        -24'sd10079,  -24'sd7192,    24'sd0,        24'sd9463,
        24'sd17461,   24'sd19842,    24'sd13890,    24'sd0,
        -24'sd17662,  -24'sd32097,   -24'sd35965,   -24'sd24852,
        24'sd0,       24'sd30892,    24'sd55595,    24'sd61755,
        24'sd42352,   24'sd0,        -24'sd52041,   -24'sd93304,
        -24'sd103408, -24'sd70876,   24'sd0,        24'sd87511,
        24'sd157849,  24'sd176540,   24'sd122555,   24'sd0,
        -24'sd157560, -24'sd293008,  -24'sd341234,  -24'sd250085,
        24'sd0,       24'sd384626,   24'sd837062,   24'sd1263444,
        24'sd1567551, 24'sd1677737
    };

    // Coefficient of one tap, rescaled to Q1.(coef_bits-1); taps past the table are zero
    function automatic logic signed [63:0] tap_coef(input int idx, input int coef_bits);
        logic signed [63:0] v;
        logic        [63:0] mag;
        int                 h;
        if (idx >= ROM_LEN) begin
            return '0;
        end
        h   = (idx <= ROM_HALF) ? idx : (ROM_LEN - 1 - idx);
        v   = 64'(ROM_HALF_TBL[h]);
        mag = (v < 0) ? 64'(-v) : 64'(v);
        if (coef_bits >= 24) begin
            mag = mag << (coef_bits - 24);
        end else begin
            mag = mag >> (24 - coef_bits);
        end
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;      // write phase into delay line, clear accumulator
        logic step;       // read one tap and its coefficient
        logic round;      // round the accumulator
        logic sat;        // saturate the rounded sum into the result
        logic clear_res;  // force a zero result
        logic load_out;   // move the result into the output register
    } sfl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_tap;
        logic pipe_empty;
    } sfl_stat_t;

endpackage

// ----- sv/sfl_tick_if.sv -----
// Input channel: one audio tick request with host and hold flags.
interface sfl_tick_if;
    logic valid;
    logic ready;
    logic host_ready;
    logic bypass;
    logic mute;

    modport source (output valid, output host_ready, output bypass, output mute, input ready);
    modport sink   (input valid, input host_ready, input bypass, input mute, output ready);
endinterface

// ----- sv/sfl_sample_if.sv -----
// Output channel: one stereo sample request.
interface sfl_sample_if #(
    parameter int SAMPLE_W = sfl_pkg::SAMPLE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- sv/sfl_ctrl.sv -----
// Controller: sequences one tick through write, tap sweep, rounding, saturation and output, or a zero result.
module sfl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               host_ready,
    input  logic               bypass,
    input  logic               mute,
    output logic               out_valid,
    input  logic               out_ready,
    output sfl_pkg::sfl_cmd_t  cmd,
    input  sfl_pkg::sfl_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_DRAIN,
        ST_ROUND,
        ST_SAT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   first_pending_reg, first_pending_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next         = state_reg;
        first_pending_next = first_pending_reg;
        cmd                = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (host_ready && !first_pending_reg && !(bypass || mute))
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        // zero result; start-up tick only clears its flag
                        cmd.clear_res = 1'b1;
                        state_next    = ST_EMIT;
                        if (host_ready)
                        begin
                            first_pending_next = 1'b0;
                        end
                    end
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            first_pending_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            first_pending_reg <= first_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Start-up flag never comes back once cleared
    a_first_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(first_pending_reg))
        else $error("start-up flag set again after reset");

    // Rounding only sees a fully drained accumulator
    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> stat.pipe_empty)
        else $error("rounding before MAC pipeline drained");

    // A waiting result is dropped only after it was taken
    a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("result dropped without being taken");

endmodule

// ----- sv/sfl_datapath.sv -----
// Datapath: phase oscillator, tap memory, shared multiply-accumulate, rounding and output register.
module sfl_datapath #(
    parameter int TAPS        = sfl_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sfl_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sfl_pkg::PHASE_BITS-1:0] cfg_wr_data,
    input  sfl_pkg::sfl_cmd_t             cmd,
    output sfl_pkg::sfl_stat_t            stat,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int PB        = sfl_pkg::PHASE_BITS;
    localparam int ADDR_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W     = $clog2(TAPS + 1);
    localparam int PROD_W    = PB + 1 + COEF_BITS;
    localparam int ACC_W     = PROD_W + $clog2(TAPS) + 1;
    localparam int SUM_SHIFT = PB + COEF_BITS - SAMPLE_BITS;
    localparam int RND_W     = ACC_W - SUM_SHIFT;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TAPS);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (SUM_SHIFT - 1));
    localparam logic signed [RND_W-1:0] SAT_HI =
        RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI;

    // Tap memory (circular delay line)
    logic [PB-1:0] mem [TAPS];
    logic [PB-1:0] rd_data_reg;

    logic [PB-1:0]     saw_step_reg;
    logic [PB-1:0]     phase_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] tap_idx_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              s1_vld_reg;
    logic              s2_vld_reg;

    logic signed [COEF_BITS-1:0] coef_now;
    logic signed [COEF_BITS-1:0] coef_reg;
    logic signed [PROD_W-1:0]    tap_ext;
    logic signed [PROD_W-1:0]    coef_ext;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [RND_W-1:0]     rnd_reg;
    logic signed [SAMPLE_BITS-1:0] sat_next;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic                          tap_live;

    // Coefficient of the tap being read; taps not yet written read as zero
    assign coef_now = COEF_BITS'(sfl_pkg::tap_coef(int'(tap_idx_reg), COEF_BITS));
    assign tap_live = (CNT_W'(tap_idx_reg) < fill_reg);

    // Write the new phase, read one tap per step; drop taps never written
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mem[wp_reg] <= phase_reg;
        end
        if (cmd.step)
        begin
            rd_data_reg <= tap_live ? mem[rd_ptr_reg] : '0;
            coef_reg    <= tap_live ? coef_now : '0;
        end
    end

    // Advance oscillator, pointers, fill count and pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_step_reg <= sfl_pkg::STEP_RESET;
            phase_reg    <= '0;
            wp_reg       <= '0;
            rd_ptr_reg   <= '0;
            tap_idx_reg  <= '0;
            fill_reg     <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                saw_step_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                phase_reg   <= phase_reg + saw_step_reg;
                wp_reg      <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                rd_ptr_reg  <= wp_reg;
                tap_idx_reg <= '0;
                if (fill_reg != FULL_CNT)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.step)
            begin
                rd_ptr_reg  <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - 1'b1;
                tap_idx_reg <= tap_idx_reg + 1'b1;
            end
            s1_vld_reg <= cmd.step;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Multiply tap by coefficient
    assign tap_ext  = PROD_W'($signed({1'b0, rd_data_reg}));
    assign coef_ext = PROD_W'(coef_reg);

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= tap_ext * coef_ext;
        end
    end

    // Saturate the rounded sum
    always_comb
    begin
        if (rnd_reg > SAT_HI)
        begin
            sat_next = SAMPLE_BITS'(SAT_HI);
        end
        else if (rnd_reg < SAT_LO)
        begin
            sat_next = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            sat_next = SAMPLE_BITS'(rnd_reg);
        end
    end

    // Accumulate, round, hold result and output
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.round)
        begin
            rnd_reg <= RND_W'((acc_reg + RND_HALF) >>> SUM_SHIFT);
        end
        if (cmd.clear_res)
        begin
            res_reg <= '0;
        end
        else if (cmd.sat)
        begin
            res_reg <= sat_next;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign stat.last_tap   = (tap_idx_reg == LAST_ADDR);
    assign stat.pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign sample          = out_data_reg;

    // Fill count never passes the line length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond delay line length");

    // Write and read pointers stay inside the memory
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= LAST_ADDR) && (rd_ptr_reg <= LAST_ADDR))
        else $error("delay line pointer out of range");

    // Each tick that writes a phase leaves a live tap behind it
    a_fill_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (fill_reg != '0) && (tap_idx_reg == '0))
        else $error("tap sweep not set up after phase write");

endmodule

// ----- sv/sawtooth_fir_lowpass_unit.sv -----
// A computed tick passes the start, tap sweep, drain, round, saturate and emit states before its
// sample is loaded; no new tick is taken until then, and the sweep is set by the single shared
// multiplier reading one tap of the delay line memory per cycle.
// Ticks without host, the start-up tick, bypass and mute give a zero sample through the emit
// state alone; emit waits while an earlier sample has not been taken.
// Reset: asynchronous, active low; phase and delay line read as zero, step is 83886,
// the start-up tick is pending; no clearing pass, unwritten taps are masked by a fill count.
module sawtooth_fir_lowpass_unit #(
    parameter int TAPS        = sfl_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sfl_pkg::COEF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sfl_tick_if.sink                       tick,
    sfl_sample_if.source                   sample,
    input  logic                           cfg_wr_en,
    input  logic [sfl_pkg::PHASE_BITS-1:0] cfg_wr_data
);

    sfl_pkg::sfl_cmd_t             cmd;
    sfl_pkg::sfl_stat_t            stat;
    logic signed [SAMPLE_BITS-1:0] sample_data;

    // Sequence each tick
    sfl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (tick.valid),
        .in_ready   (tick.ready),
        .host_ready (tick.host_ready),
        .bypass     (tick.bypass),
        .mute       (tick.mute),
        .out_valid  (sample.valid),
        .out_ready  (sample.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Oscillator, filter and output register
    sfl_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (sample_data)
    );

    // Same sample on both channels
    assign sample.left_sample  = sample_data;
    assign sample.right_sample = sample_data;

endmodule

// ----- tb/sv/sawtooth_fir_lowpass_unit_tb.sv -----
// Self-checking testbench for the sawtooth FIR low-pass unit, with its sample scoreboard.

// Predict the stereo sample of every tick request and check the samples that come back
class sample_board;
    localparam int                 NTAPS   = sfl_pkg::TAPS_DEF;
    localparam longint             SAT_MAX = 64'sd8388607;
    localparam int                 MAX_MSG = 10;

    logic [23:0]        phase_line [NTAPS];
    logic [23:0]        saw_phase;
    logic [23:0]        saw_step;
    bit                 startup_pending;
    logic signed [23:0] expected_samples [$];
    int                 mismatches;
    int                 tick_count;
    int                 computed_count;
    int                 saturated_count;
    int                 sample_count;

    function new();
        foreach (phase_line[i]) phase_line[i] = '0;
        saw_phase       = '0;
        saw_step        = sfl_pkg::STEP_RESET;
        startup_pending = 1'b1;
        mismatches      = 0;
        tick_count      = 0;
        computed_count  = 0;
        saturated_count = 0;
        sample_count    = 0;
    endfunction

    function void set_step(logic [23:0] value);
        saw_step = value;
    endfunction

    function int waiting();
        return expected_samples.size();
    endfunction

    // Note an accepted tick request and queue the sample it must give
    function void note_tick(bit host_ready, bit bypass, bit mute);
        longint acc;
        longint rounded;
        int     h;
        tick_count++;
        if (!host_ready) begin
            expected_samples.push_back('0);
            return;
        end
        if (startup_pending) begin
            startup_pending = 1'b0;
            expected_samples.push_back('0);
            return;
        end
        if (bypass || mute) begin
            expected_samples.push_back('0);
            return;
        end
        // Load the head, run the multiply-accumulate, then shift the line
        phase_line[0] = saw_phase;
        acc = 0;
        for (int i = 0; i < NTAPS; i++) begin
            if (i < sfl_pkg::ROM_LEN) begin
                h = (i <= sfl_pkg::ROM_HALF) ? i : (sfl_pkg::ROM_LEN - 1 - i);
                acc += longint'(phase_line[i]) * longint'(sfl_pkg::ROM_HALF_TBL[h]);
            end
        end
        for (int i = NTAPS - 1; i > 0; i--) begin
            phase_line[i] = phase_line[i - 1];
        end
        saw_phase = saw_phase + saw_step;
        // Round half up, then clip to plus or minus full scale
        rounded = (acc + (64'sd1 <<< 23)) >>> 24;
        if (rounded > SAT_MAX) begin
            rounded = SAT_MAX;
            saturated_count++;
        end else if (rounded < -SAT_MAX) begin
            rounded = -SAT_MAX;
            saturated_count++;
        end
        computed_count++;
        expected_samples.push_back(rounded[23:0]);
    endfunction

    // Compare one accepted sample request against the oldest prediction
    function void check_sample(logic signed [23:0] left, logic signed [23:0] right);
        logic signed [23:0] want;
        sample_count++;
        if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_MSG) begin
                $display("[%0t] unexpected sample: left=%0d right=%0d", $realtime, left, right);
            end
            return;
        end
        want = expected_samples.pop_front();
        if (left !== want || right !== want) begin
            mismatches++;
            if (mismatches <= MAX_MSG) begin
                $display("[%0t] sample %0d mismatch: expected %0d, got left=%0d right=%0d",
                         $realtime, sample_count, want, left, right);
            end
        end
    endfunction
endclass

module sawtooth_fir_lowpass_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 205;
    localparam int RANDOM_PHASES   = 6;
    localparam int SETTLE_CYCLES   = 130;
    localparam int DRAIN_LIMIT     = 20000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [sfl_pkg::PHASE_BITS-1:0] cfg_wr_data;

    sfl_tick_if   tick_ch ();
    sfl_sample_if #(.SAMPLE_W(sfl_pkg::SAMPLE_BITS_DEF)) smp_ch ();

    sample_board board;
    bit          no_idle;
    int          stall_left;
    int          steps_written;

    sawtooth_fir_lowpass_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_ch),
        .sample      (smp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock, 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // End the run as failed if the block hangs
    initial
    begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Drive ready on the sample side, stalling in random bursts
    initial
    begin
        smp_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0) begin
                smp_ch.ready = 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                smp_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 17) - 1;
            end else begin
                smp_ch.ready = 1'b1;
            end
        end
    end

    // Check every accepted sample request
    always @(posedge clk)
    begin
        if (rst_n && smp_ch.valid && smp_ch.ready) begin
            board.check_sample(smp_ch.left_sample, smp_ch.right_sample);
        end
    end

    // Offer one tick request and hold it until taken
    task automatic send_tick(input bit host_ready, input bit bypass, input bit mute);
        @(negedge clk);
        tick_ch.valid      = 1'b1;
        tick_ch.host_ready = host_ready;
        tick_ch.bypass     = bypass;
        tick_ch.mute       = mute;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        board.note_tick(host_ready, bypass, mute);
    endtask

    // Drop valid for a burst of cycles
    task automatic tick_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            tick_ch.valid = 1'b0;
        end
    endtask

    // Stop sending and wait for every predicted sample to come back
    task automatic drain();
        int spent;
        spent = 0;
        tick_gap(1);
        while (board.waiting() != 0 && spent < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spent++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the oscillator step; only called with the block idle
    task automatic write_step(input logic [23:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        board.set_step(value);
        steps_written++;
    endtask

    // One random tick: mostly computed ticks, some holds and host drop-outs
    task automatic random_tick();
        bit host_ready;
        bit bypass;
        bit mute;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            tick_gap($urandom_range(1, 17));
        end
        host_ready = ($urandom_range(0, 99) >= 6);
        bypass     = ($urandom_range(0, 9) == 0);
        mute       = ($urandom_range(0, 9) == 0);
        send_tick(host_ready, bypass, mute);
    endtask

    initial
    begin
        logic [23:0] phase_steps [RANDOM_PHASES];

        board              = new();
        no_idle            = 1'b0;
        steps_written      = 0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.host_ready = 1'b0;
        tick_ch.bypass     = 1'b0;
        tick_ch.mute       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Host not ready, then the start-up tick with both holds set
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        // Computed ticks at the reset step, holds and a host drop-out in between
        repeat (5) send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        repeat (2) send_tick(1'b1, 1'b0, 1'b0);
        drain();
        // Largest step: the phase wraps on every tick
        write_step(24'hFFFFFF);
        repeat (4) send_tick(1'b1, 1'b0, 1'b0);
        drain();
        // Zero step: the phase stands still
        write_step(24'h000000);
        repeat (3) send_tick(1'b1, 1'b0, 1'b0);
        drain();

        // Random phases, each under its own step
        phase_steps[0] = 24'd1;
        phase_steps[1] = 24'($urandom);
        phase_steps[2] = 24'hFFFFFF;
        phase_steps[3] = 24'($urandom_range(0, 4095));
        phase_steps[4] = sfl_pkg::STEP_RESET;
        phase_steps[5] = 24'h800000 | 24'($urandom_range(0, 255));
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_step(phase_steps[p]);
            no_idle = (p == RANDOM_PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Pause mid-phase until the pipeline is empty
                if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
                    drain();
                end
                random_tick();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d tick requests under %0d step settings: %0d computed, %0d clipped.",
                 board.tick_count, steps_written + 1, board.computed_count,
                 board.saturated_count);
        $display("Checked %0d samples, %0d mismatches, %0d still waiting.",
                 board.sample_count, board.mismatches, board.waiting());
        if (board.mismatches == 0 && board.waiting() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- sawtooth_fir_lowpass_unit.f -----
sv/sfl_pkg.sv
sv/sfl_tick_if.sv
sv/sfl_sample_if.sv
sv/sfl_ctrl.sv
sv/sfl_datapath.sv
sv/sawtooth_fir_lowpass_unit.sv
tb/sv/sawtooth_fir_lowpass_unit_tb.sv
